FILE: rtl/pfbm_pkg.sv
package pfbm_pkg;

    localparam int PERM_SIZE       = 256;
    localparam int PERM_W          = $clog2(PERM_SIZE);
    localparam int MAX_OCTAVES_DEF = 8;
    localparam int FRAC_BITS       = 16;
    localparam int COORD_W         = 32;
    localparam int FREQ_W          = 24;
    localparam int OCT_W           = 4;
    localparam int PROD_W          = COORD_W + FREQ_W;
    localparam int COORD_POINT     = 40;
    localparam int OUT_W           = 24;
    localparam int DOT_W           = FRAC_BITS + 3;
    localparam int FADE_W          = FRAC_BITS + 4;
    localparam int ONE_W           = FRAC_BITS + 1;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;

    localparam logic [OCT_W-1:0]  OCT_RESET  = OCT_W'(1);
    localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(83886);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic REG_OCTAVE_COUNT   = 1'b0;
    localparam logic REG_BASE_FREQUENCY = 1'b1;

    // Permutation table write ports, one per replica group of every lane.
    typedef struct packed {
        logic              a_we;
        logic [PERM_W-1:0] a_idx;
        logic [PERM_W-1:0] a_val;
        logic              b_we;
        logic [PERM_W-1:0] b_idx;
        logic [PERM_W-1:0] b_val;
    } pfbm_wr_t;

endpackage

FILE: rtl/pfbm_octave.sv
module pfbm_octave #(
    parameter int LANE = 0
) (
    input  logic                                clk,
    input  logic                                en,
    input  pfbm_pkg::pfbm_wr_t                  wr,
    input  logic signed [pfbm_pkg::PROD_W-1:0]  px,
    input  logic signed [pfbm_pkg::PROD_W-1:0]  py,
    output logic signed [pfbm_pkg::DOT_W-1:0]   oct
);
    import pfbm_pkg::*;

    localparam int POINT = COORD_POINT - LANE;
    localparam logic [1:0] GRAD_PP = 2'd0;
    localparam logic [1:0] GRAD_MP = 2'd1;
    localparam logic [1:0] GRAD_MM = 2'd2;
    localparam logic [1:0] GRAD_PM = 2'd3;
    localparam logic [FADE_W-1:0] FIFTEEN_ONE = FADE_W'(15 << FRAC_BITS);
    localparam logic [FADE_W-1:0] TEN_ONE     = FADE_W'(10 << FRAC_BITS);
    localparam logic [FADE_W-1:0] SIX         = FADE_W'(6);
    localparam logic signed [DOT_W-1:0] ONE_S = DOT_W'(1 << FRAC_BITS);

    function automatic logic [FADE_W-1:0] fade_d(input logic [FRAC_BITS-1:0] t);
        logic [FADE_W-1:0]           c;
        logic [FADE_W+FRAC_BITS-1:0] p;
        c = FIFTEEN_ONE - FADE_W'(t) * SIX;
        p = c * t;
        return p[FRAC_BITS +: FADE_W];
    endfunction

    function automatic logic [FRAC_BITS-1:0] mulq(input logic [FRAC_BITS-1:0] a,
                                                  input logic [FRAC_BITS-1:0] b);
        logic [2*FRAC_BITS-1:0] p;
        p = a * b;
        return p[FRAC_BITS +: FRAC_BITS];
    endfunction

    function automatic logic [ONE_W-1:0] fade_out(input logic [FRAC_BITS-1:0] t3,
                                                  input logic [FADE_W-1:0] e);
        logic [FADE_W+FRAC_BITS-1:0] p;
        p = t3 * e;
        return p[FRAC_BITS +: ONE_W];
    endfunction

    function automatic logic signed [DOT_W-1:0] dot(input logic [PERM_W-1:0] h,
                                                    input logic signed [DOT_W-1:0] dx,
                                                    input logic signed [DOT_W-1:0] dy);
        logic signed [DOT_W-1:0] r;
        case (h[1:0])
            GRAD_PP: r = dx + dy;
            GRAD_MP: r = dy - dx;
            GRAD_MM: r = -dx - dy;
            GRAD_PM: r = dx - dy;
        endcase
        return r;
    endfunction

    // a + floor((b - a) * f / 2^FRAC_BITS)
    function automatic logic signed [DOT_W-1:0] lerp(input logic [ONE_W-1:0] f,
                                                     input logic signed [DOT_W-1:0] a,
                                                     input logic signed [DOT_W-1:0] b);
        logic signed [DOT_W:0]         diff;
        logic signed [DOT_W+ONE_W+1:0] p;
        logic signed [DOT_W:0]         sh;
        logic signed [DOT_W:0]         r;
        diff = b - a;
        p    = diff * $signed({1'b0, f});
        sh   = p[FRAC_BITS +: DOT_W+1];
        r    = a + sh;
        return r[DOT_W-1:0];
    endfunction

    logic [PERM_W-1:0] perm_a  [PERM_SIZE];
    logic [PERM_W-1:0] perm_b0 [PERM_SIZE];
    logic [PERM_W-1:0] perm_b1 [PERM_SIZE];

    logic [PERM_W-1:0]    cx, cx1, cy;
    logic [FRAC_BITS-1:0] fx, fy;

    logic [PERM_W-1:0]    c_p0_reg, c_p1_reg, c_cy_reg;
    logic [FRAC_BITS-1:0] c_fx_reg, c_fy_reg, c_t2x_reg, c_t2y_reg;
    logic [FADE_W-1:0]    c_dx_reg, c_dy_reg;

    logic [PERM_W-1:0]    a0, a0n, a1, a1n;
    logic [PERM_W-1:0]    d_h00_reg, d_h01_reg, d_h10_reg, d_h11_reg;
    logic [FRAC_BITS-1:0] d_fx_reg, d_fy_reg, d_t3x_reg, d_t3y_reg;
    logic [FADE_W-1:0]    d_ex_reg, d_ey_reg;

    logic signed [DOT_W-1:0] dx0, dx1, dy0, dy1;
    logic signed [DOT_W-1:0] e_bl_reg, e_br_reg, e_tl_reg, e_tr_reg;
    logic [ONE_W-1:0]        e_u_reg, e_v_reg;

    logic signed [DOT_W-1:0] f_left_reg, f_right_reg;
    logic [ONE_W-1:0]        f_u_reg;

    logic signed [DOT_W-1:0] n_lerp;
    logic signed [DOT_W-1:0] oct_reg;

    assign cx  = px[POINT +: PERM_W];
    assign cy  = py[POINT +: PERM_W];
    assign cx1 = cx + PERM_W'(1);
    assign fx  = px[POINT-FRAC_BITS +: FRAC_BITS];
    assign fy  = py[POINT-FRAC_BITS +: FRAC_BITS];

    // First table lookup: perm[cx] and perm[cx + 1].
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (wr.a_we)
            begin
                perm_a[wr.a_idx] <= wr.a_val;
            end
            c_p0_reg  <= perm_a[cx];
            c_p1_reg  <= perm_a[cx1];
            c_cy_reg  <= cy;
            c_fx_reg  <= fx;
            c_fy_reg  <= fy;
            c_t2x_reg <= mulq(fx, fx);
            c_t2y_reg <= mulq(fy, fy);
            c_dx_reg  <= fade_d(fx);
            c_dy_reg  <= fade_d(fy);
        end
    end

    assign a0  = c_p0_reg + c_cy_reg;
    assign a0n = a0 + PERM_W'(1);
    assign a1  = c_p1_reg + c_cy_reg;
    assign a1n = a1 + PERM_W'(1);

    // Second lookup gives the four corner hashes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (wr.b_we)
            begin
                perm_b0[wr.b_idx] <= wr.b_val;
                perm_b1[wr.b_idx] <= wr.b_val;
            end
            d_h00_reg <= perm_b0[a0];
            d_h01_reg <= perm_b0[a0n];
            d_h10_reg <= perm_b1[a1];
            d_h11_reg <= perm_b1[a1n];
            d_fx_reg  <= c_fx_reg;
            d_fy_reg  <= c_fy_reg;
            d_t3x_reg <= mulq(c_t2x_reg, c_fx_reg);
            d_t3y_reg <= mulq(c_t2y_reg, c_fy_reg);
            d_ex_reg  <= TEN_ONE - c_dx_reg;
            d_ey_reg  <= TEN_ONE - c_dy_reg;
        end
    end

    assign dx0 = $signed({3'b000, d_fx_reg});
    assign dy0 = $signed({3'b000, d_fy_reg});
    assign dx1 = dx0 - ONE_S;
    assign dy1 = dy0 - ONE_S;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_bl_reg <= dot(d_h00_reg, dx0, dy0);
            e_tl_reg <= dot(d_h01_reg, dx0, dy1);
            e_br_reg <= dot(d_h10_reg, dx1, dy0);
            e_tr_reg <= dot(d_h11_reg, dx1, dy1);
            e_u_reg  <= fade_out(d_t3x_reg, d_ex_reg);
            e_v_reg  <= fade_out(d_t3y_reg, d_ey_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_left_reg  <= lerp(e_v_reg, e_bl_reg, e_tl_reg);
            f_right_reg <= lerp(e_v_reg, e_br_reg, e_tr_reg);
            f_u_reg     <= e_u_reg;
        end
    end

    assign n_lerp = lerp(f_u_reg, f_left_reg, f_right_reg);

    // The arithmetic shift applies the octave weight 2^-k, rounding toward minus infinity.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oct_reg <= n_lerp >>> LANE;
        end
    end

    assign oct = oct_reg;

endmodule

FILE: rtl/perlin_fbm_noise_2d_core.sv
// Fractal 2D Perlin noise: one item enters per cycle while item_stall is low, and the result
// of an evaluate item appears on result_valid; a load item writes one permutation entry and
// gives no result. Each item passes the input register, coordinate multiply, two registered
// table lookups, fade, two lerp levels and a two-level octave sum. Every octave lane keeps
// its own copies of the permutation table, so the table must be loaded through load items
// before points are evaluated. While a result waits under result_stall the whole pipeline
// holds, and item_stall follows it. Registers sit at byte address 0 (octave_count) and 4
// (base_frequency).
module perlin_fbm_noise_2d_core #(
    parameter int MAX_OCTAVES = pfbm_pkg::MAX_OCTAVES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pfbm_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [pfbm_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [pfbm_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic                                  op,
    input  logic [pfbm_pkg::PERM_W-1:0]           table_index,
    input  logic [pfbm_pkg::PERM_W-1:0]           table_value,
    input  logic signed [pfbm_pkg::COORD_W-1:0]   x_coord,
    input  logic signed [pfbm_pkg::COORD_W-1:0]   y_coord,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [pfbm_pkg::OUT_W-1:0]     noise_value
);
    import pfbm_pkg::*;

    localparam int GROUPS = (MAX_OCTAVES + 3) / 4;
    localparam int SUM_W  = DOT_W + 4;

    logic [OCT_W-1:0]  octave_count_reg;
    logic [FREQ_W-1:0] base_frequency_reg;
    logic              reg_sel;

    logic en;

    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic e_valid_reg, f_valid_reg, g_valid_reg, h_valid_reg, out_valid_reg;
    logic a_op_reg, b_op_reg, c_op_reg, d_op_reg, e_op_reg, f_op_reg, g_op_reg, h_op_reg;
    logic [PERM_W-1:0] a_idx_reg, a_val_reg, b_idx_reg, b_val_reg, c_idx_reg, c_val_reg;
    logic signed [COORD_W-1:0] a_x_reg, a_y_reg;
    logic signed [PROD_W-1:0]  b_px_reg, b_py_reg;

    pfbm_wr_t wr;

    logic signed [DOT_W-1:0] lane_oct [MAX_OCTAVES];
    logic [MAX_OCTAVES-1:0]  active;
    logic                    oc_big;

    logic signed [SUM_W-1:0] part_next [GROUPS];
    logic signed [SUM_W-1:0] h_part_reg [GROUPS];
    logic signed [SUM_W-1:0] sum_next;
    logic signed [OUT_W-1:0] noise_reg;

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_ADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg   <= OCT_RESET;
            base_frequency_reg <= FREQ_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_OCTAVE_COUNT:   octave_count_reg   <= pwdata[OCT_W-1:0];
                REG_BASE_FREQUENCY: base_frequency_reg <= pwdata[FREQ_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_OCTAVE_COUNT:   prdata = APB_DATA_W'(octave_count_reg);
            REG_BASE_FREQUENCY: prdata = APB_DATA_W'(base_frequency_reg);
        endcase
    end

    // One enable moves every stage; the output register is the only place a result waits.
    assign en         = !(out_valid_reg && result_stall);
    assign item_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            g_valid_reg   <= 1'b0;
            h_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= item_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= d_valid_reg;
            f_valid_reg   <= e_valid_reg;
            g_valid_reg   <= f_valid_reg;
            h_valid_reg   <= g_valid_reg;
            out_valid_reg <= h_valid_reg && (h_op_reg == OP_EVAL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_op_reg  <= op;
            a_idx_reg <= table_index;
            a_val_reg <= table_value;
            a_x_reg   <= x_coord;
            a_y_reg   <= y_coord;

            b_op_reg  <= a_op_reg;
            b_idx_reg <= a_idx_reg;
            b_val_reg <= a_val_reg;
            b_px_reg  <= a_x_reg * $signed({1'b0, base_frequency_reg});
            b_py_reg  <= a_y_reg * $signed({1'b0, base_frequency_reg});

            c_op_reg  <= b_op_reg;
            c_idx_reg <= b_idx_reg;
            c_val_reg <= b_val_reg;

            d_op_reg  <= c_op_reg;
            e_op_reg  <= d_op_reg;
            f_op_reg  <= e_op_reg;
            g_op_reg  <= f_op_reg;
            h_op_reg  <= g_op_reg;

            h_part_reg <= part_next;
            noise_reg  <= OUT_W'(sum_next);
        end
    end

    // A load writes each table copy as it passes the stage that reads that copy, so
    // items ahead of it read the old entry and items behind it read the new one.
    assign wr.a_we  = b_valid_reg && (b_op_reg == OP_LOAD);
    assign wr.a_idx = b_idx_reg;
    assign wr.a_val = b_val_reg;
    assign wr.b_we  = c_valid_reg && (c_op_reg == OP_LOAD);
    assign wr.b_idx = c_idx_reg;
    assign wr.b_val = c_val_reg;

    for (genvar k = 0; k < MAX_OCTAVES; k++)
    begin : g_lane
        pfbm_octave #(
            .LANE (k)
        ) u_octave (
            .clk (clk),
            .en  (en),
            .wr  (wr),
            .px  (b_px_reg),
            .py  (b_py_reg),
            .oct (lane_oct[k])
        );
    end

    // Octave counts above the lane count behave as a single octave.
    assign oc_big = {1'b0, octave_count_reg} > (OCT_W+1)'(MAX_OCTAVES);

    always_comb
    begin
        for (int k = 0; k < MAX_OCTAVES; k++)
        begin
            active[k] = oc_big ? (k == 0) : ((OCT_W+1)'(k) < {1'b0, octave_count_reg});
        end
    end

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            part_next[g] = '0;
            for (int j = 0; j < 4; j++)
            begin
                if ((4 * g + j < MAX_OCTAVES) && active[(4 * g + j) % MAX_OCTAVES])
                begin
                    part_next[g] = part_next[g] + lane_oct[(4 * g + j) % MAX_OCTAVES];
                end
            end
        end
    end

    // The weighted octave sum stays far inside the 24-bit output range.
    always_comb
    begin
        sum_next = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            sum_next = sum_next + h_part_reg[g];
        end
    end

    assign result_valid = out_valid_reg;
    assign noise_value  = noise_reg;

endmodule
